// ----- hdl/stack_machine_executor_unit_assert.svh -----
// Assertion macros for the stack machine executor, empty when synthesized.
`ifndef STACK_MACHINE_EXECUTOR_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked implication check, silenced while reset is held.
`define SMEU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check that an expression never becomes true.
`define SMEU_ASSERT_NEVER(lbl, expr, msg) \
    `SMEU_ASSERT(lbl, !(expr), msg)
`else
`define SMEU_ASSERT(lbl, prop, msg)
`define SMEU_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hdl/sme_pkg.sv -----
// Shared types and constants of the stack machine executor.
`timescale 1ns / 1ps

package sme_pkg;

    localparam int SME_STACK_DEPTH = 256;
    localparam int SME_WORD_W      = 32;
    localparam int SME_DIV_STEPS   = 32;

    typedef enum logic [3:0] {
        OP_PUSH = 4'd0,
        OP_ADD  = 4'd1,
        OP_POP  = 4'd2,
        OP_SET  = 4'd3,
        OP_HALT = 4'd4,
        OP_MUL  = 4'd5,
        OP_DIV  = 4'd6,
        OP_MOD  = 4'd7,
        OP_XOR  = 4'd8,
        OP_OR   = 4'd9,
        OP_AND  = 4'd10
    } t_opcode;

    // Register target of a set instruction that loads the stack count.
    localparam logic [3:0] SP_TARGET = 4'd10;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_OVER   = 3'd1,
        ST_UNDER  = 3'd2,
        ST_BADDIV = 3'd3,
        ST_HALTED = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_WAIT,
        S_RD_B,
        S_LATCH_B,
        S_CALC,
        S_DIV_WAIT,
        S_WR_B,
        S_WR_T,
        S_RESP
    } t_state;

    // Result flags, packed with value_valid in the lowest bit.
    typedef struct packed {
        t_status status;
        logic    halted;
        logic    value_valid;
    } t_resp_flags;

endpackage

// ----- hdl/sme_stack_ram.sv -----
// Operand stack storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module sme_stack_ram
    import sme_pkg::*;
#(
    parameter int DEPTH  = SME_STACK_DEPTH,
    parameter int ADDR_W = $clog2(SME_STACK_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  logic [SME_WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]     i_raddr,
    output logic [SME_WORD_W-1:0] o_rdata
);

    logic [SME_WORD_W-1:0] r_mem [DEPTH];
    logic [SME_WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sme_div_unit.sv -----
// Unsigned restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module sme_div_unit
    import sme_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SME_WORD_W-1:0] i_dividend,
    input  logic [SME_WORD_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [SME_WORD_W-1:0] o_quotient,
    output logic [SME_WORD_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(SME_DIV_STEPS);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SME_WORD_W-1:0] r_rem;
    logic [SME_WORD_W-1:0] r_quo;
    logic [SME_WORD_W-1:0] r_div;
    logic [SME_WORD_W:0]   rem_sh;
    logic [SME_WORD_W:0]   diff;
    logic                  last_step;

    // The dividend shifts out of the quotient register as quotient bits shift in.
    always_comb begin
        rem_sh = {r_rem, r_quo[SME_WORD_W-1]};
        diff   = rem_sh - {1'b0, r_div};
    end

    assign last_step = r_busy && (r_cnt == CNT_W'(SME_DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!diff[SME_WORD_W]) begin
                r_rem <= diff[SME_WORD_W-1:0];
                r_quo <= {r_quo[SME_WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[SME_WORD_W-1:0];
                r_quo <= {r_quo[SME_WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- hdl/stack_machine_executor_unit.sv -----
// Stack machine executor top level: sequencer around a one-port-pair stack memory.
// Each word runs alone: it is taken in idle and decoded, a pop reads the top word,
// and two-operand operations read both operands, compute, wait for the 32-step divider
// on a good divide or modulo of a nonnegative dividend, and write back if not faulted.
// A finished result sits in an output register, so the next word is taken meanwhile.
// Synchronous active-low reset empties the stack and clears halt; memory is not cleared.
`timescale 1ns / 1ps
`include "stack_machine_executor_unit_assert.svh"

module stack_machine_executor_unit
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = SME_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Instruction stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] immediate
    input  logic [7:0]  i_s_axis_tuser,   // [3:0] op, [7:4] target_index
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] value
    output logic [4:0]  o_m_axis_tuser    // [0] value_valid, [1] halted, [4:2] status
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    // Control state.
    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic                  r_halt;
    logic                  r_out_valid;

    // The current word and its working values.
    logic [3:0]            r_op;
    logic [SME_WORD_W-1:0] r_imm;
    logic [3:0]            r_tgt;
    logic [SME_WORD_W-1:0] r_a;        // top of stack
    logic [SME_WORD_W-1:0] r_b;        // word below the top
    logic [SME_WORD_W-1:0] r_res;      // result for the lower slot
    logic [SME_WORD_W-1:0] r_top;      // value left in the upper slot
    logic                  r_wr_top;
    logic [SME_WORD_W-1:0] n_res;
    logic [SME_WORD_W-1:0] n_top;
    logic                  n_wr_top;
    logic [SME_WORD_W-1:0] r_value;
    logic                  r_vvalid;
    t_status               r_status;

    // Output register.
    logic [SME_WORD_W-1:0] r_out_data;
    t_resp_flags           r_out_flags;

    // Memory and divider connections.
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [SME_WORD_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [SME_WORD_W-1:0] mem_rdata;
    logic                  div_start;
    logic                  div_done;
    logic [SME_WORD_W-1:0] div_quo;
    logic [SME_WORD_W-1:0] div_rem;

    // Decode helpers.
    logic                  in_acc;
    logic                  out_free;
    logic                  is_bin;
    logic                  is_divmod;
    logic                  stack_full;
    logic                  stack_empty;
    logic                  bin_short;
    logic                  a_pos;
    logic                  b_neg;
    logic [CNT_W-1:0]      cnt_m1;
    logic [CNT_W-1:0]      cnt_m2;
    logic [SME_WORD_W:0]   set_n;
    logic                  set_over;
    logic                  set_under;
    logic [SME_WORD_W-1:0] mul_lo;

    assign in_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free    = !r_out_valid || i_m_axis_tready;
    assign is_bin      = (r_op == OP_ADD) || ((r_op >= OP_MUL) && (r_op <= OP_AND));
    assign is_divmod   = (r_op == OP_DIV) || (r_op == OP_MOD);
    assign stack_full  = r_count >= CNT_W'(STACK_DEPTH);
    assign stack_empty = r_count == '0;
    assign bin_short   = (r_count < CNT_W'(2)) || (r_count > CNT_W'(STACK_DEPTH));
    assign a_pos       = !r_a[SME_WORD_W-1] && (r_a != '0);
    assign b_neg       = r_b[SME_WORD_W-1];
    assign cnt_m1      = r_count - CNT_W'(1);
    assign cnt_m2      = r_count - CNT_W'(2);

    // Set loads immediate + 1 into the count; the sum is taken one bit wider, signed.
    assign set_n     = {r_imm[SME_WORD_W-1], r_imm} + (SME_WORD_W + 1)'(1);
    assign set_over  = $signed(set_n) > $signed((SME_WORD_W + 1)'(STACK_DEPTH));
    assign set_under = set_n[SME_WORD_W];

    // Low half of the product is all that survives the wrap.
    assign mul_lo = SME_WORD_W'(r_a * r_b);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_halt) begin
                    n_state = S_RESP;
                end else if (r_op == OP_POP) begin
                    n_state = stack_empty ? S_RESP : S_POP_WAIT;
                end else if (is_bin) begin
                    n_state = bin_short ? S_RESP : S_RD_B;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_POP_WAIT: n_state = S_RESP;
            S_RD_B:     n_state = S_LATCH_B;
            S_LATCH_B:  n_state = S_CALC;
            S_CALC: begin
                if (is_divmod && !a_pos) begin
                    n_state = S_RESP;
                end else if (is_divmod && !b_neg) begin
                    n_state = S_DIV_WAIT;
                end else begin
                    n_state = S_WR_B;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_WR_B;
                end
            end
            S_WR_B: n_state = S_WR_T;
            S_WR_T: n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer. Every read of a word starts only after all writes of
    // the previous word are done, so no forwarding path is needed around the memory.
    always_comb begin
        o_s_axis_tready = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = r_count[ADDR_W-1:0];
        mem_wdata       = r_imm;
        mem_raddr       = cnt_m2[ADDR_W-1:0];
        div_start       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            S_DECODE: begin
                // Fetch the top word for pop and for two-operand work.
                mem_raddr = cnt_m1[ADDR_W-1:0];
                mem_we    = !r_halt && (r_op == OP_PUSH) && !stack_full;
            end
            S_CALC: begin
                div_start = is_divmod && a_pos && !b_neg;
            end
            S_WR_B: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_m2[ADDR_W-1:0];
                mem_wdata = r_res;
            end
            S_WR_T: begin
                mem_we    = r_wr_top;
                mem_waddr = cnt_m1[ADDR_W-1:0];
                mem_wdata = r_top;
            end
            default: begin
            end
        endcase
    end

    // Result of a two-operand operation and what is left in the upper slot.
    always_comb begin
        n_wr_top = 1'b0;
        n_top    = '0 - r_a;
        n_res    = '0;
        priority if (r_op == OP_ADD) begin
            n_res = r_b + r_a;
        end else if (r_op == OP_MUL) begin
            // A positive multiplier also leaves the multiplicand above the product.
            if (a_pos) begin
                n_res    = mul_lo;
                n_top    = r_b;
                n_wr_top = 1'b1;
            end
        end else if (is_divmod) begin
            if (a_pos) begin
                n_wr_top = 1'b1;
                // A negative dividend ends the subtraction loop at once.
                if (b_neg) begin
                    n_res = (r_op == OP_DIV) ? '1 : r_b + r_a;
                end
            end
        end else if (r_op == OP_XOR) begin
            n_res = r_b ^ r_a;
        end else if (r_op == OP_OR) begin
            n_res = r_b | r_a;
        end else begin
            n_res = r_b & r_a;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DECODE) && !r_halt) begin
                unique case (r_op)
                    OP_PUSH: begin
                        if (!stack_full) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                    OP_POP: begin
                        if (!stack_empty) begin
                            r_count <= cnt_m1;
                        end
                    end
                    OP_SET: begin
                        if ((r_tgt == SP_TARGET) && !set_over && !set_under) begin
                            r_count <= set_n[CNT_W-1:0];
                        end
                    end
                    OP_HALT: r_halt <= 1'b1;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_WR_T) begin
                r_count <= cnt_m1;
            end
            if ((r_state == S_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current word.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_op     <= i_s_axis_tuser[3:0];
                    r_tgt    <= i_s_axis_tuser[7:4];
                    r_imm    <= i_s_axis_tdata;
                    r_value  <= '0;
                    r_vvalid <= 1'b0;
                    r_status <= ST_OK;
                end
            end
            S_DECODE: begin
                if (r_halt) begin
                    r_status <= ST_HALTED;
                end else if ((r_op == OP_PUSH) && stack_full) begin
                    r_status <= ST_OVER;
                end else if ((r_op == OP_POP) && stack_empty) begin
                    r_status <= ST_UNDER;
                end else if (is_bin && bin_short) begin
                    r_status <= ST_UNDER;
                end else if ((r_op == OP_SET) && (r_tgt == SP_TARGET) && set_over) begin
                    r_status <= ST_OVER;
                end else if ((r_op == OP_SET) && (r_tgt == SP_TARGET) && set_under) begin
                    r_status <= ST_UNDER;
                end
            end
            S_POP_WAIT: begin
                r_value  <= mem_rdata;
                r_vvalid <= 1'b1;
            end
            S_RD_B: begin
                r_a <= mem_rdata;
            end
            S_LATCH_B: begin
                r_b <= mem_rdata;
            end
            S_CALC: begin
                r_wr_top <= n_wr_top;
                r_top    <= n_top;
                r_res    <= n_res;
                if (is_divmod && !a_pos) begin
                    r_status <= ST_BADDIV;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    r_res <= (r_op == OP_DIV) ? div_quo : div_rem;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESP) && out_free) begin
            r_out_data              <= r_value;
            r_out_flags.value_valid <= r_vvalid;
            r_out_flags.halted      <= r_halt;
            r_out_flags.status      <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_flags;

    sme_stack_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sme_div_unit u_div_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_b),
        .i_divisor   (r_a),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Once halted, the machine stays halted until reset.
    `SMEU_ASSERT(a_halt_sticky, r_halt |=> r_halt, "halt flag dropped")
    // The stack count moves only while decoding or on the last write-back.
    `SMEU_ASSERT(a_count_quiet, (r_state != S_DECODE && r_state != S_WR_T) |=> $stable(r_count),
        "stack count changed outside decode or write-back")
    // A popped word is only ever reported with a clean status.
    `SMEU_ASSERT_NEVER(a_pop_status, o_m_axis_tvalid && r_out_flags.value_valid &&
        (r_out_flags.status != ST_OK), "popped word reported with a fault status")
    // The divider finishes only while the sequencer waits for it.
    `SMEU_ASSERT(a_div_done, div_done |-> (r_state == S_DIV_WAIT), "divider done out of turn")

endmodule

// ----- bench/stack_machine_executor_unit_tb.sv -----
// Self-checking testbench for the stack machine executor: directed and random words with a scoreboard.
`timescale 1ns / 1ps

module stack_machine_executor_unit_tb;
    import sme_pkg::*;

    localparam int DEPTH = SME_STACK_DEPTH;

    // One result word: value on tdata, flags on tuser with value_valid lowest.
    typedef struct packed {
        logic [31:0] value;
        t_resp_flags flags;
    } exec_result_t;

    // Tracks the operand stack as the executor should see it and holds the result
    // words still to come back, oldest first.
    class stack_result_scoreboard;
        logic [31:0]  stack_words [DEPTH];
        int           depth;
        // Highest stack count ever reached by pushes: every slot below it has been
        // written, so the stimulus never lets the count climb past it.
        int           high_water;
        bit           halted;
        exec_result_t awaited_results [$];
        int           results_seen;
        int           mismatches;

        function new();
            foreach (stack_words[i]) stack_words[i] = '0;
            depth        = 0;
            high_water   = 0;
            halted       = 1'b0;
            results_seen = 0;
            mismatches   = 0;
        endfunction

        // Executes one accepted instruction word and queues the result it must produce.
        function void execute_word(logic [3:0] op, logic [31:0] imm, logic [3:0] tgt);
            exec_result_t res;
            logic [31:0]  a, b, r;
            longint       n;
            bit           ok;
            res = '0;
            res.flags.status = ST_OK;
            ok = 1'b1;
            if (halted) begin
                res.flags.status = ST_HALTED;
            end else begin
                case (op)
                    OP_PUSH: begin
                        if (depth >= DEPTH) begin
                            res.flags.status = ST_OVER;
                        end else begin
                            stack_words[depth] = imm;
                            depth++;
                            if (depth > high_water) high_water = depth;
                        end
                    end
                    OP_POP: begin
                        if (depth == 0) begin
                            res.flags.status = ST_UNDER;
                        end else begin
                            depth--;
                            res.value = stack_words[depth];
                            res.flags.value_valid = 1'b1;
                        end
                    end
                    OP_SET: begin
                        // Only the stack pointer target does anything; the count
                        // becomes the immediate plus one.
                        if (tgt == SP_TARGET) begin
                            n = $signed(imm);
                            n = n + 1;
                            if (n > DEPTH) res.flags.status = ST_OVER;
                            else if (n < 0) res.flags.status = ST_UNDER;
                            else depth = int'(n);
                        end
                    end
                    OP_HALT: begin
                        halted = 1'b1;
                    end
                    OP_ADD, OP_MUL, OP_DIV, OP_MOD, OP_XOR, OP_OR, OP_AND: begin
                        if (depth < 2) begin
                            res.flags.status = ST_UNDER;
                        end else begin
                            // a is the top word, b the one below it.
                            a = stack_words[depth - 1];
                            b = stack_words[depth - 2];
                            r = '0;
                            case (op)
                                OP_ADD: r = b + a;
                                OP_MUL: begin
                                    // A multiplier of zero or less gives zero and leaves
                                    // the top slot alone; otherwise it keeps b.
                                    if (!a[31] && a != 0) begin
                                        r = a * b;
                                        stack_words[depth - 1] = b;
                                    end
                                end
                                OP_DIV, OP_MOD: begin
                                    if (a[31] || a == 0) begin
                                        ok = 1'b0;
                                    end else begin
                                        // A negative dividend ends the subtraction loop
                                        // at once: quotient -1, remainder b + a.
                                        if (b[31]) r = (op == OP_DIV) ? '1 : b + a;
                                        else r = (op == OP_DIV) ? b / a : b % a;
                                        stack_words[depth - 1] = 32'd0 - a;
                                    end
                                end
                                OP_XOR: r = b ^ a;
                                OP_OR:  r = b | a;
                                default: r = b & a;
                            endcase
                            if (ok) begin
                                stack_words[depth - 2] = r;
                                depth--;
                            end else begin
                                res.flags.status = ST_BADDIV;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            res.flags.halted = halted;
            awaited_results.push_back(res);
        endfunction

        // Compares one accepted result word with the oldest one awaited.
        function void check_result_word(logic [31:0] data, logic [4:0] user);
            exec_result_t want;
            t_resp_flags  got;
            got = t_resp_flags'(user);
            results_seen++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with none awaited: value=%h flags=%b",
                             results_seen, data, user);
                return;
            end
            want = awaited_results.pop_front();
            if (data !== want.value || got.value_valid !== want.flags.value_valid ||
                got.halted !== want.flags.halted || got.status !== want.flags.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: expected value=%h valid=%b halted=%b status=%0d,",
                              " got value=%h valid=%b halted=%b status=%0d"},
                             results_seen, want.value, want.flags.value_valid,
                             want.flags.halted, want.flags.status, data, got.value_valid,
                             got.halted, got.status);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] immediate
    logic [7:0]  i_s_axis_tuser = '0;   // [3:0] op, [7:4] target_index
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [31:0] value
    logic [4:0]  o_m_axis_tuser;        // [0] value_valid, [1] halted, [4:2] status

    stack_result_scoreboard sb = new();

    // Stretches where a side never idles, toggled at random.
    bit quiet_in  = 1'b0;
    bit quiet_out = 1'b0;
    int words_sent = 0;

    stack_machine_executor_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Drives one instruction word after a random gap and returns at the edge that
    // accepts it. Valid stays high into the next word when that one has no gap.
    task automatic send_word(logic [3:0] op, logic [31:0] imm, logic [3:0] tgt);
        int gap;
        if ($urandom_range(0, 39) == 0) quiet_in = !quiet_in;
        gap = quiet_in ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= imm;
        i_s_axis_tuser  <= {tgt, op};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.execute_word(op, imm, tgt);
        words_sent++;
    endtask

    task automatic push_word(logic [31:0] imm);
        send_word(OP_PUSH, imm, 4'($urandom));
    endtask

    task automatic plain_word(t_opcode op);
        send_word(op, $urandom, 4'($urandom));
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'($urandom_range(1, 20));
            2: return 32'd0 - 32'($urandom_range(1, 20));
            3: begin
                case ($urandom_range(0, 2))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Divisors are mostly small and positive so that division does real work.
    function automatic logic [31:0] pick_divisor();
        if ($urandom_range(0, 3) != 0) return 32'($urandom_range(1, 40));
        return pick_operand();
    endfunction

    function automatic t_opcode pick_binop();
        case ($urandom_range(0, 8))
            0: return OP_ADD;
            1: return OP_MUL;
            2, 3: return OP_DIV;
            4, 5: return OP_MOD;
            6: return OP_XOR;
            7: return OP_OR;
            default: return OP_AND;
        endcase
    endfunction

    // Set of the stack pointer, sometimes out of range; a legal count is never
    // allowed above the slots already written.
    task automatic set_pointer(bit wild);
        logic [31:0] imm;
        longint      n;
        if (!wild) begin
            imm = 32'($urandom_range(0, sb.high_water)) - 32'd1;
        end else begin
            case ($urandom_range(0, 3))
                0: imm = 32'd255;
                1: imm = 32'd256;
                2: imm = 32'hFFFF_FFFE;
                default: imm = $urandom;
            endcase
            n = $signed(imm);
            n = n + 1;
            if (n >= 0 && n <= DEPTH && n > sb.high_water) imm = 32'(sb.high_water) - 32'd1;
        end
        send_word(OP_SET, imm, SP_TARGET);
    endtask

    // Result side: random stalls, one result word checked per handshake.
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
            stall = quiet_out ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            sb.check_result_word(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    initial begin
        logic [31:0] tgt;
        int          round;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-stack faults, wrapping add, multiply by a non-positive
        // multiplier, negative dividend, zero divisor, logic ops and every set case.
        plain_word(OP_POP);
        plain_word(OP_ADD);
        push_word(32'h7FFF_FFFF);
        push_word(32'h0000_0001);
        plain_word(OP_ADD);
        push_word(32'hFFFF_FFFD);
        plain_word(OP_MUL);
        push_word(32'd100);
        push_word(32'd7);
        plain_word(OP_DIV);
        push_word(32'hFFFF_FFCE);
        push_word(32'd7);
        plain_word(OP_MOD);
        push_word(32'd0);
        plain_word(OP_DIV);
        plain_word(OP_XOR);
        plain_word(OP_OR);
        plain_word(OP_AND);
        plain_word(OP_POP);
        send_word(OP_SET, 32'hFFFF_FFFF, SP_TARGET);
        send_word(OP_SET, 32'd256, SP_TARGET);
        send_word(OP_SET, 32'hFFFF_FFFE, SP_TARGET);
        send_word(OP_SET, 32'd5, 4'd3);
        send_word(4'd15, 32'hA5A5_5A5A, 4'd15);

        // Random part: operand pairs followed by an operation, with loose words,
        // pointer sets and a few full fills and drains of the stack mixed in.
        round = 0;
        while (words_sent < 1225) begin
            round++;
            if (round == 150 || round == 450) begin
                while (sb.depth < DEPTH) push_word(pick_operand());
                push_word($urandom);
            end else if (round == 300 || round == 600) begin
                while (sb.depth > 0) plain_word(OP_POP);
                plain_word(OP_POP);
            end
            case ($urandom_range(0, 99)) inside
                [0:29]: begin
                    push_word(pick_operand());
                    push_word(pick_divisor());
                    plain_word(pick_binop());
                end
                [30:49]: push_word(pick_operand());
                [50:64]: plain_word(OP_POP);
                [65:74]: plain_word(pick_binop());
                [75:84]: set_pointer(1'b0);
                [85:89]: set_pointer(1'b1);
                [90:94]: begin
                    tgt = $urandom_range(0, 15);
                    if (tgt == SP_TARGET) tgt = 11;
                    send_word(OP_SET, $urandom, tgt[3:0]);
                end
                default: send_word(4'($urandom_range(11, 15)), $urandom, 4'($urandom));
            endcase
        end

        // Halt last, since only reset clears it; everything after must be flagged.
        plain_word(OP_HALT);
        push_word($urandom);
        plain_word(OP_POP);
        set_pointer(1'b0);
        plain_word(OP_DIV);
        plain_word(OP_HALT);
        send_word(4'd12, $urandom, 4'd10);
        i_s_axis_tvalid <= 1'b0;

        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
